// ===== rtl/sha_pkg.sv =====
// sha-256 stream hasher package: payload structs, round constants, fsm states
// and the command/status structs between controller and datapath
`default_nettype none
package sha_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       end_of_message;
	} sha_in_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} sha_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_FOLD,
		ST_PAD,
		ST_EMIT
	} sha_state_t;

	// byte source for the absorb path
	typedef enum logic [1:0] {
		SRC_INPUT,
		SRC_PAD80,
		SRC_ZERO,
		SRC_LEN
	} sha_src_t;

	typedef struct packed {
		logic     absorb;
		sha_src_t src;
		logic     start_rounds;
		logic     round_step;
		logic     fold;
		logic     latch_len;
		logic     reset_hash;
	} sha_cmd_t;

	typedef struct packed {
		logic [5:0] pos;
		logic [5:0] round_idx;
	} sha_stat_t;

	localparam logic [7:0] PadByte = 8'h80;
	localparam logic [5:0] LenPos  = 6'd56;

	localparam logic [31:0] InitHash [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

endpackage
`default_nettype wire

// ===== rtl/sha_datapath.sv =====
// sha-256 datapath: byte packing, bit count, rolling message schedule,
// round registers and hash words; depends on sha_pkg
`default_nettype none
module sha_datapath
	import sha_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire sha_cmd_t   cmd,
	input  wire logic [7:0] in_byte,
	output sha_stat_t       stat,
	input  wire logic [2:0] emit_idx,
	output logic [31:0]     emit_word
);

	logic [63:0] bit_count_q;
	logic [63:0] len_q;
	logic [5:0]  round_q;
	logic [31:0] w_q [16];
	logic [31:0] v_q [8];
	logic [31:0] h_q [8];

	logic [7:0]  abs_byte;
	logic [5:0]  pos;
	logic [31:0] s0, s1, w_new, t1, t2, ch, maj, e_sum, a_sum, x, y, a, e;

	assign pos = bit_count_q[8:3];
	assign stat.pos = pos;
	assign stat.round_idx = round_q;
	assign emit_word = h_q[emit_idx];

	always_comb begin
		case (cmd.src)
			SRC_INPUT: abs_byte = in_byte;
			SRC_PAD80: abs_byte = PadByte;
			SRC_ZERO:  abs_byte = 8'h00;
			SRC_LEN:   abs_byte = len_q[63:56];
			default:   abs_byte = 8'h00;
		endcase
	end

	// schedule over a 16-word window, w_q[0] is the current round word
	always_comb begin
		x = w_q[14];
		y = w_q[1];
		s1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
		s0 = {y[6:0], y[31:7]} ^ {y[17:0], y[31:18]} ^ (y >> 3);
		w_new = s1 + w_q[9] + s0 + w_q[0];
		a = v_q[0];
		e = v_q[4];
		e_sum = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
		a_sum = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
		ch = (e & v_q[5]) ^ (~e & v_q[6]);
		maj = (a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]);
		t1 = v_q[7] + e_sum + ch + RoundK[round_q] + w_q[0];
		t2 = a_sum + maj;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_count_q <= '0;
			round_q <= '0;
			for (int i = 0; i < 8; i++) h_q[i] <= InitHash[i];
		end else begin
			if (cmd.absorb) begin
				bit_count_q <= bit_count_q + 64'd8;
				w_q[pos[5:2]][(3 - pos[1:0]) * 8 +: 8] <= abs_byte;
				if (cmd.src == SRC_LEN) len_q <= {len_q[55:0], 8'h00};
			end
			if (cmd.latch_len) len_q <= bit_count_q;
			if (cmd.start_rounds) begin
				round_q <= '0;
				for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
			end
			if (cmd.round_step) begin
				round_q <= round_q + 6'd1;
				for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
				w_q[15] <= w_new;
				v_q[7] <= v_q[6];
				v_q[6] <= v_q[5];
				v_q[5] <= v_q[4];
				v_q[4] <= v_q[3] + t1;
				v_q[3] <= v_q[2];
				v_q[2] <= v_q[1];
				v_q[1] <= v_q[0];
				v_q[0] <= t1 + t2;
			end
			if (cmd.fold)
				for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
			if (cmd.reset_hash) begin
				bit_count_q <= '0;
				for (int i = 0; i < 8; i++) h_q[i] <= InitHash[i];
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/sha_ctrl.sv =====
// sha-256 controller: input handshake, padding sequencer, round sequencing
// and digest emission; depends on sha_pkg
`default_nettype none
module sha_ctrl
	import sha_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	input  wire sha_in_t   in_item,
	output logic           in_stall,
	output logic           out_valid,
	input  wire logic      out_stall,
	output sha_cmd_t       cmd,
	input  wire sha_stat_t stat,
	output logic [2:0]     emit_idx
);

	sha_state_t state_q, state_d;
	logic       fin_q, fin_d;      // finishing the message
	logic       len_phase_q, len_phase_d;
	logic [2:0] idx_q, idx_d;

	assign emit_idx = idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fin_q <= 1'b0;
			len_phase_q <= 1'b0;
			idx_q <= '0;
		end else begin
			state_q <= state_d;
			fin_q <= fin_d;
			len_phase_q <= len_phase_d;
			idx_q <= idx_d;
		end
	end

	always_comb begin
		state_d = state_q;
		fin_d = fin_q;
		len_phase_d = len_phase_q;
		idx_d = idx_q;
		cmd = '0;
		cmd.src = SRC_INPUT;
		in_stall = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.absorb = in_item.byte_present;
					fin_d = in_item.end_of_message;
					if (in_item.byte_present && stat.pos == 6'd63) begin
						cmd.start_rounds = 1'b1;
						state_d = ST_ROUND;
					end else if (in_item.end_of_message) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_ROUND: begin
				cmd.round_step = 1'b1;
				if (stat.round_idx == 6'd63) state_d = ST_FOLD;
			end
			ST_FOLD: begin
				cmd.fold = 1'b1;
				if (!fin_q) state_d = ST_IDLE;
				else if (len_phase_q && stat.pos == 6'd0) begin
					idx_d = '0;
					state_d = ST_EMIT;
				end else state_d = ST_PAD;
			end
			ST_PAD: begin
				// first pad cycle latches length and writes the marker byte
				cmd.absorb = 1'b1;
				if (!len_phase_q) begin
					cmd.src = SRC_ZERO;
					if (idx_q == 3'd0) begin
						cmd.src = SRC_PAD80;
						cmd.latch_len = 1'b1;
						idx_d = 3'd1;
					end
					if (stat.pos == LenPos && idx_q != 3'd0) begin
						cmd.src = SRC_LEN;
						len_phase_d = 1'b1;
					end
				end else begin
					cmd.src = SRC_LEN;
				end
				if (stat.pos == 6'd63) begin
					cmd.start_rounds = 1'b1;
					state_d = ST_ROUND;
				end
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					idx_d = idx_q + 3'd1;
					if (idx_q == 3'd7) begin
						cmd.reset_hash = 1'b1;
						fin_d = 1'b0;
						len_phase_d = 1'b0;
						idx_d = '0;
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/sha256_stream_hasher.sv =====
// sha-256 stream hasher top level: controller plus datapath
// depends on sha_pkg, sha_ctrl, sha_datapath
//
// Takes one byte per cycle while no block is being compressed, padded or
// emitted. A byte that fills a 64-byte block starts the 64 rounds and then
// a fold, one round per cycle on the single round unit. End of message runs
// the padding one byte per cycle (9 to 72 bytes, two blocks when the tail
// is 56 bytes or more) with a compression per padded block, then presents
// the eight digest words one per cycle while out_stall is low, word 0 first,
// and returns to the initial hash values.
`default_nettype none
module sha256_stream_hasher
	import sha_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_stall,
	input  wire sha_in_t  in_data,
	output logic          out_valid,
	input  wire logic     out_stall,
	output sha_out_t      out_data
);

	sha_cmd_t    cmd;
	sha_stat_t   stat;
	logic [2:0]  emit_idx;
	logic [31:0] emit_word;

	sha_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_item(in_data), .in_stall,
		.out_valid, .out_stall, .cmd, .stat, .emit_idx
	);

	sha_datapath u_dp (
		.clk, .arst_n, .cmd, .in_byte(in_data.data_byte), .stat,
		.emit_idx, .emit_word
	);

	assign out_data.digest_word = emit_word;
	assign out_data.word_index = emit_idx;
	assign out_data.last_word = (emit_idx == 3'd7);

endmodule
`default_nettype wire

// ===== rtl/sha_checker.sv =====
// port-level checker for the sha-256 stream hasher, bound to the top level
// depends on sha_pkg
`default_nettype none
module sha_checker
	import sha_pkg::*;
(
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     in_valid,
	input wire logic     in_stall,
	input wire sha_in_t  in_data,
	input wire logic     out_valid,
	input wire logic     out_stall,
	input wire sha_out_t out_data
);

	// no input taken while digest words are shown
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input open during emit");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.last_word == (out_data.word_index == 3'd7)))
		else $error("last_word mismatch");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !out_data.last_word |=>
		out_valid && out_data.word_index == $past(out_data.word_index) + 3'd1)
		else $error("digest word order");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled output changed");

endmodule

bind sha256_stream_hasher sha_checker u_chk (.*);
`default_nettype wire
